// ===== hw/rtl/kmd_pkg.sv =====
// kmd_pkg: shared types, constants and helpers for the key matrix debouncer.
// Depends on nothing; imported by key_matrix_debouncer.
package kmd_pkg;

  localparam int RowW        = 12;  // width of one column sample
  localparam int RowIdxInW   = 4;   // width of the row index field
  localparam int CountW      = 7;   // width of the pressed-key count
  localparam int ScanW       = 8;   // width of the debounce scan count
  localparam int PopW        = 4;   // popcount of one row, 0..12
  localparam int DefRows     = 9;
  localparam int DefCols     = 12;

  localparam logic [ScanW-1:0]  DebounceReset = 8'd5;
  localparam logic [CountW-1:0] CountMax      = 7'd127;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_COPY  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  // Mask of the columns that exist; bits at or above cols are cleared.
  function automatic logic [RowW-1:0] col_mask(input int cols);
    logic [RowW-1:0] m;
    m = '0;
    for (int i = 0; i < RowW; i++) begin
      m[i] = (i < cols);
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/key_matrix_debouncer.sv =====
// key_matrix_debouncer: scanned key matrix debouncer with one shared counter
// and a row-serial copy/popcount unit. Depends on kmd_pkg.
//
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+------------------------------------
// input     | in        | in_valid_i / in_ready_o    | row_index_i, column_bits_i,
//           |           |                            | end_of_scan_i
// result    | out       | out_valid_o / out_ready_i  | stable_row_o, settled_o, updated_o,
//           |           |                            | key_count_o
// config    | in        | cfg_valid_i / cfg_ready_o  | cfg_debounce_scans_i
//
// Flow: a request is taken in IDLE, checked against the kept sample in CHECK,
// then its result is loaded into the output register in DONE. When the
// countdown expires the copy unit walks the rows one per cycle in COPY
// (popcount and saturating add) before the request goes on to DONE.
// Reset: all kept samples, the stable matrix and the key count clear, the
// countdown and the scan count load 5.
// Stalls: a finished result waits in the output register; the next request is
// taken meanwhile and holds in DONE only if the output is still occupied.
module key_matrix_debouncer #(
  parameter int ROWS = kmd_pkg::DefRows,
  parameter int COLS = kmd_pkg::DefCols
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [kmd_pkg::ScanW-1:0]     cfg_debounce_scans_i,
  // row samples
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [kmd_pkg::RowIdxInW-1:0] row_index_i,
  input  logic [kmd_pkg::RowW-1:0]      column_bits_i,
  input  logic                         end_of_scan_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [kmd_pkg::RowW-1:0]      stable_row_o,
  output logic                         settled_o,
  output logic                         updated_o,
  output logic [kmd_pkg::CountW-1:0]    key_count_o
);
  import kmd_pkg::*;

  localparam int RowIdxW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [RowW-1:0] ColMask = col_mask(COLS);
  localparam logic [RowIdxW-1:0] LastRow = RowIdxW'(ROWS - 1);

  state_e state_q, state_d;

  logic [ScanW-1:0]   dbn_q;          // debounce scan count register
  logic [ScanW-1:0]   cnt_q, cnt_d;   // shared countdown
  logic [CountW-1:0]  total_q, total_d;

  logic [RowW-1:0] sampled_q [ROWS];
  logic [RowW-1:0] stable_q  [ROWS];

  // captured request
  logic [RowIdxW-1:0] row_q;
  logic               row_ok_q;
  logic [RowW-1:0]    cols_q;
  logic               eos_q;
  logic               copy_q, copy_d;

  logic [RowIdxW-1:0] sweep_q, sweep_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [RowW-1:0]    stable_row_q;
  logic               settled_q, updated_q;
  logic [CountW-1:0]  key_count_q;

  logic               in_fire, out_load;
  logic [RowIdxW-1:0] rd_idx;
  logic [RowW-1:0]    rd_row;
  logic               changed;
  logic [ScanW-1:0]   reload, cnt_mid;
  logic [PopW-1:0]    pop;
  logic [CountW:0]    acc_sum;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // one read port on the kept samples: request row during the check, sweep row
  // during the copy
  assign rd_idx = (state_q == ST_COPY) ? sweep_q : row_q;
  assign rd_row = sampled_q[rd_idx];

  // check step: compare and reload, then the end-of-scan countdown
  assign reload  = (dbn_q == '0) ? ScanW'(1) : dbn_q;
  assign changed = row_ok_q && (rd_row != cols_q);
  assign cnt_mid = changed ? reload : cnt_q;

  // copy unit: popcount of one row and a saturating accumulate
  assign pop     = PopW'($countones(rd_row));
  assign acc_sum = {1'b0, total_q} + (CountW + 1)'(pop);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    copy_d  = copy_q;
    sweep_d = sweep_q;
    total_d = total_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cnt_d   = cnt_mid;
        copy_d  = 1'b0;
        state_d = ST_DONE;
        if (eos_q && (cnt_mid != '0)) begin
          cnt_d = cnt_mid - ScanW'(1);
          if (cnt_mid == ScanW'(1)) begin
            copy_d  = 1'b1;
            sweep_d = '0;
            total_d = '0;
            state_d = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        total_d = acc_sum[CountW] ? CountMax : acc_sum[CountW-1:0];
        sweep_d = sweep_q + RowIdxW'(1);
        if (sweep_q == LastRow) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dbn_q       <= DebounceReset;
      cnt_q       <= DebounceReset;
      total_q     <= '0;
      copy_q      <= 1'b0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      copy_q      <= copy_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        dbn_q <= cfg_debounce_scans_i;
      end
    end
  end

  // kept samples and the stable matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        sampled_q[r] <= '0;
        stable_q[r]  <= '0;
      end
    end else begin
      if ((state_q == ST_CHECK) && changed) begin
        sampled_q[row_q] <= cols_q;
      end
      if (state_q == ST_COPY) begin
        stable_q[sweep_q] <= rd_row;
      end
    end
  end

  // request capture and result register (payload only)
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      row_q    <= RowIdxW'(row_index_i);
      row_ok_q <= ({2'b00, row_index_i} < 6'(ROWS));
      cols_q   <= column_bits_i & ColMask;
      eos_q    <= end_of_scan_i;
    end
    if (out_load) begin
      stable_row_q <= row_ok_q ? stable_q[row_q] : '0;
      settled_q    <= (cnt_q == '0);
      updated_q    <= copy_q;
      key_count_q  <= total_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign stable_row_o = stable_row_q;
  assign settled_o    = settled_q;
  assign updated_o    = updated_q;
  assign key_count_o  = key_count_q;

  // a taken request always leaves IDLE
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request taken but block still ready");

  // the copy sweep only runs once the countdown has expired
  a_copy_when_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> (cnt_q == '0))
    else $error("copy sweep with countdown still running");

  // a result that reports a copy must also report a settled matrix
  a_updated_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && updated_o) |-> settled_o)
    else $error("updated result without settled flag");

endmodule

// ===== verif/tb_key_matrix_debouncer.sv =====
// tb_key_matrix_debouncer: self-checking bench for the key matrix debouncer.
// Depends on kmd_pkg and key_matrix_debouncer; checks every result against
// an in-bench debounce model, under directed, long-countdown, back-pressure and random scans.
`timescale 1ns / 100ps

module tb_key_matrix_debouncer;
  import kmd_pkg::*;

  localparam int NumRows      = DefRows;
  localparam int NumCols      = DefCols;
  localparam int CycleLimit   = 600000;      // far above the slowest legal run
  localparam int HoldOffCycles = 240;        // long output stall, fills the block
  localparam int DrainCycles  = 2 * (3 + NumRows);
  localparam logic [RowW-1:0] LiveCols = RowW'((1 << NumCols) - 1);

  // Idling profiles for the request and result channels.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // One expected result, fields in port order.
  typedef struct packed {
    logic [RowW-1:0]   stable_row;
    logic              settled;
    logic              updated;
    logic [CountW-1:0] key_count;
  } scan_result_t;

  // DUT ports; every input known from time zero.
  logic                 clk_i                = 1'b0;
  logic                 rst_ni               = 1'b0;
  logic                 cfg_valid_i          = 1'b0;
  logic                 cfg_ready_o;
  logic [ScanW-1:0]     cfg_debounce_scans_i = '0;
  logic                 in_valid_i           = 1'b0;
  logic                 in_ready_o;
  logic [RowIdxInW-1:0] row_index_i          = '0;
  logic [RowW-1:0]      column_bits_i        = '0;
  logic                 end_of_scan_i        = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i          = 1'b0;
  logic [RowW-1:0]      stable_row_o;
  logic                 settled_o;
  logic                 updated_o;
  logic [CountW-1:0]    key_count_o;

  // Debounce model state, mirrors the block after each accepted request.
  logic [RowW-1:0]   kept_samples  [NumRows] = '{default: '0};
  logic [RowW-1:0]   stable_matrix [NumRows] = '{default: '0};
  logic [ScanW-1:0]  countdown        = DebounceReset;
  logic [ScanW-1:0]  debounce_setting = DebounceReset;
  logic [CountW-1:0] key_total        = '0;

  scan_result_t pending_results [$];

  // Keys currently held down, per row, for the random scan generator.
  logic [RowW-1:0] held_keys [NumRows] = '{default: '0};

  int send_gap_pct = 0;   // chance per cycle that the sender idles
  int stall_pct    = 0;   // chance per cycle that the receiver stalls
  int hold_len     = 0;   // long hold-off request, written at negedge only
  int stall_left   = 0;
  int cycle_count  = 0;
  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int copies_seen  = 0;
  int cfg_writes   = 0;

  key_matrix_debouncer #(
    .ROWS (NumRows),
    .COLS (NumCols)
  ) u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_debounce_scans_i (cfg_debounce_scans_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .row_index_i          (row_index_i),
    .column_bits_i        (column_bits_i),
    .end_of_scan_i        (end_of_scan_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .stable_row_o         (stable_row_o),
    .settled_o            (settled_o),
    .updated_o            (updated_o),
    .key_count_o          (key_count_o)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Model of one request: store a changed sample and reload the countdown,
  // then count down on end of scan; expiry copies every row and recounts.
  function automatic scan_result_t debounce_step(input logic [RowIdxInW-1:0] row,
                                                 input logic [RowW-1:0] cols,
                                                 input logic eos);
    scan_result_t res;
    logic [RowW-1:0] live;
    logic in_range;
    int total;
    live = cols & LiveCols;           // columns past the matrix edge drop out
    in_range = (row < NumRows);       // rows past the edge store nothing
    res.updated = 1'b0;
    if (in_range && kept_samples[row] != live) begin
      kept_samples[row] = live;
      countdown = (debounce_setting == '0) ? ScanW'(1) : debounce_setting;
    end
    // Already settled: end of scan leaves the count at zero, no copy.
    if (eos && countdown != '0) begin
      countdown = countdown - 1'b1;
      if (countdown == '0) begin
        total = 0;
        for (int r = 0; r < NumRows; r++) begin
          stable_matrix[r] = kept_samples[r];
          total += $countones(kept_samples[r]);
        end
        key_total = (total > CountMax) ? CountMax : CountW'(total);
        res.updated = 1'b1;
      end
    end
    res.stable_row = in_range ? stable_matrix[row] : '0;
    res.settled    = (countdown == '0);
    res.key_count  = key_total;
    return res;
  endfunction

  // Result side: ready follows the stall profile unless a long hold-off runs.
  always @(posedge clk_i) begin
    if (hold_len != 0) begin
      stall_left = hold_len;
      hold_len   = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    scan_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: row %03h settled %b updated %b count %0d",
               stable_row_o, settled_o, updated_o, key_count_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.updated) copies_seen++;
        if (stable_row_o !== want.stable_row) begin
          $error("stable_row: expected %03h, got %03h", want.stable_row, stable_row_o);
          errors++;
        end
        if (settled_o !== want.settled) begin
          $error("settled: expected %b, got %b", want.settled, settled_o);
          errors++;
        end
        if (updated_o !== want.updated) begin
          $error("updated: expected %b, got %b", want.updated, updated_o);
          errors++;
        end
        if (key_count_o !== want.key_count) begin
          $error("key_count: expected %0d, got %0d", want.key_count, key_count_o);
          errors++;
        end
      end
    end
  end

  // Offer one row sample, optionally after random idle cycles. Valid stays
  // high into the next request when no gap is drawn.
  task automatic send_sample(input logic [RowIdxInW-1:0] row,
                             input logic [RowW-1:0] cols,
                             input logic eos);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    row_index_i   <= row;
    column_bits_i <= cols;
    end_of_scan_i <= eos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(debounce_step(row, cols, eos));
    items_sent++;
  endtask

  // Block idle: request channel quiet and every result back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_debounce(input logic [ScanW-1:0] scans);
    wait_drained();
    cfg_valid_i          <= 1'b1;
    cfg_debounce_scans_i <= scans;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    debounce_setting = scans;
    cfg_writes++;
  endtask

  // Profile changes land at negedge so the ready process sees them cleanly.
  task automatic set_idling(input idle_mode_e mode);
    @(negedge clk_i);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct = 85;
        stall_pct    = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0;
        stall_pct    = 85;
      end
      IDLE_BOTH: begin
        send_gap_pct = 22;
        stall_pct    = 22;
      end
      default: begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
    endcase
    @(posedge clk_i);
  endtask

  // Full scans of the held keys; keys change now and then, rows bounce, and
  // a few stray requests (any row, any flag) are mixed in.
  task automatic run_scans(input int scans);
    logic [RowW-1:0] cols;
    int r;
    for (int s = 0; s < scans; s++) begin
      if ($urandom_range(99) < 35) begin
        r = $urandom_range(NumRows - 1);
        held_keys[r] ^= RowW'(1 << $urandom_range(RowW - 1));
      end
      if ($urandom_range(99) < 4) held_keys[$urandom_range(NumRows - 1)] = RowW'($urandom);
      for (int row = 0; row < NumRows; row++) begin
        if ($urandom_range(99) < 7)
          send_sample(RowIdxInW'($urandom), RowW'($urandom), 1'($urandom_range(1)));
        cols = held_keys[row];
        if ($urandom_range(99) < 8) cols ^= RowW'(1 << $urandom_range(RowW - 1));
        send_sample(RowIdxInW'(row), cols, row == NumRows - 1);
      end
    end
  endtask

  // Edges of the fields and the special cases, first at the reset scan count.
  task automatic test_directed();
    send_sample(4'd0, 12'hFFF, 1'b0);       // every column
    send_sample(4'd8, 12'h001, 1'b0);       // last row
    send_sample(4'd15, 12'hABC, 1'b1);      // bad row: dropped, end of scan kept
    repeat (4) send_sample(4'd9, 12'h000, 1'b1);  // counts down to a copy
    send_sample(4'd0, 12'hFFF, 1'b1);       // end of scan while settled
    send_sample(4'd1, 12'h555, 1'b1);       // new sample and end of scan at once
    send_sample(4'd1, 12'hAAA, 1'b0);
    send_sample(4'd12, 12'h5A5, 1'b0);
    send_sample(4'd6, 12'h000, 1'b0);
    // Scan count of zero behaves as one.
    write_debounce(8'd0);
    send_sample(4'd2, 12'h800, 1'b1);
    send_sample(4'd2, 12'h7FF, 1'b1);
    // Every key down: largest key count.
    write_debounce(8'd1);
    for (int r = 0; r < NumRows; r++)
      send_sample(RowIdxInW'(r), 12'hFFF, r == NumRows - 1);
    wait_drained();
  endtask

  // Largest scan count: settles only after 255 quiet scans.
  task automatic test_long_countdown();
    write_debounce(8'd255);
    send_sample(4'd3, 12'h0F0, 1'b0);
    repeat (255) send_sample(RowIdxInW'($urandom_range(15, NumRows)), RowW'($urandom), 1'b1);
    send_sample(4'd3, 12'h0F0, 1'b1);
    wait_drained();
  endtask

  // Output held off long enough that the block backs up onto its input.
  task automatic test_backpressure();
    write_debounce(8'd2);
    set_idling(IDLE_NONE);
    @(negedge clk_i);
    hold_len = HoldOffCycles;
    @(posedge clk_i);
    for (int i = 0; i < 3 * NumRows; i++)
      send_sample(RowIdxInW'(i % NumRows), RowW'($urandom), (i % NumRows) == NumRows - 1);
    wait_drained();
  endtask

  // Random scans through each idling profile, two scan counts per profile.
  task automatic test_random_scans();
    idle_mode_e modes [4] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
    logic [ScanW-1:0] scans;
    foreach (modes[m]) begin
      set_idling(modes[m]);
      for (int half = 0; half < 2; half++) begin
        case ($urandom_range(5))
          0:       scans = 8'd0;
          1:       scans = 8'd1;
          2:       scans = 8'd2;
          3:       scans = 8'd3;
          default: scans = ScanW'($urandom_range(6, 1));
        endcase
        write_debounce(scans);
        run_scans(8);
      end
    end
    set_idling(IDLE_NONE);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_long_countdown();
    test_backpressure();
    test_random_scans();

    // Let any stray result surface before closing.
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d row samples and %0d results, %0d matrix copies,",
             items_sent, results_seen, copies_seen);
    $display("with %0d scan count writes from 0 to 255 under four idling profiles",
             cfg_writes);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
